// ----- rtl/ucr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the unicycle trajectory rollout.
package ucr_pkg;

  localparam int unsigned MaxStepsDef    = 64;
  localparam int unsigned CordicItersDef = 16;

  localparam int unsigned StepCountW = 7;
  localparam int unsigned TimeStepW  = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP  = 1'b1;

  localparam logic [StepCountW-1:0] STEP_COUNT_RST = 7'd10;
  localparam logic [TimeStepW-1:0]  TIME_STEP_RST  = 16'd6554;

  localparam logic signed [32:0] CORDIC_GAIN   = 33'sd652032874;
  localparam logic signed [31:0] RAD_TO_HALF   = 32'sd1335088;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] angular_velocity;
  } ucr_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] orient_z;
    logic signed [15:0] orient_w;
    logic               last_pose;
  } ucr_out_t;

  function automatic logic [31:0] ucr_atan(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/unicycle_trajectory_rollout.sv -----
`timescale 1ns / 1ps
// Top level of the unicycle trajectory rollout with its sequencer, CORDIC and multiplier.
//
// One input transaction carries a command of linear and angular velocity. The block
// rolls a pose out from the origin and delivers min(step_count, MAX_STEPS) output
// transactions, one pose each, with last_pose set on the final one.
// Both channels use valid and stall; in_stall_o is high while a command is in work.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write it only while idle, which the block itself does not enforce. Setup runs the
// states S_MUL_V, S_MUL_W, S_MUL_T and S_CAP_T; each pose then runs S_CMOVE, S_MUL_X,
// S_MUL_Y, S_ADD_Y, S_CQUAT and S_EMIT. The single CORDIC rotator runs one iteration
// per cycle and is used twice per pose, and the single multiplier is used for both
// position axes. Reset clears the sequencer and output valid, and loads step_count 10
// and time_step 6554. When the receiver stalls, the finished pose waits in the output
// register and the sequencer, after computing the next pose, holds in S_EMIT until the
// waiting pose is taken; the next command can be accepted while the final pose still waits.
module unicycle_trajectory_rollout
  import ucr_pkg::*;
#(
  parameter int unsigned MAX_STEPS    = MaxStepsDef,
  parameter int unsigned CORDIC_ITERS = CordicItersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ucr_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ucr_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MAX_STEPS + 1);
  localparam int unsigned IterW = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_V = 4'd1;
  localparam logic [3:0] S_MUL_W = 4'd2;
  localparam logic [3:0] S_MUL_T = 4'd3;
  localparam logic [3:0] S_CAP_T = 4'd4;
  localparam logic [3:0] S_CMOVE = 4'd5;
  localparam logic [3:0] S_MUL_X = 4'd6;
  localparam logic [3:0] S_MUL_Y = 4'd7;
  localparam logic [3:0] S_ADD_Y = 4'd8;
  localparam logic [3:0] S_CQUAT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [StepCountW-1:0] step_count_q;
  logic [TimeStepW-1:0]  time_step_q;
  ucr_in_t               cmd_q, cmd_d;
  logic [CntW-1:0]       steps_q, steps_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic signed [24:0]    step_delta_q, step_delta_d;
  logic [31:0]           turn_delta_q, turn_delta_d;
  logic [31:0]           heading_q, heading_d;
  logic signed [31:0]    acc_x_q, acc_x_d;
  logic signed [31:0]    acc_y_q, acc_y_d;
  logic signed [64:0]    mul_q, mul_d;
  logic signed [32:0]    mul_a;
  logic signed [31:0]    mul_b;

  logic signed [32:0]    cx_q, cx_d, cy_q, cy_d;
  logic signed [33:0]    cz_q, cz_d;
  logic                  flip_q, flip_d;
  logic [IterW-1:0]      iter_q, iter_d;
  logic                  c_start;
  logic [31:0]           c_ang;
  logic [31:0]           c_ang_f;
  logic                  c_flip;
  logic signed [32:0]    xs, ys;
  logic signed [33:0]    c_atan;
  logic                  c_last;
  logic signed [32:0]    cos_v, sin_v;

  logic                  out_valid_q, out_valid_d;
  ucr_out_t              out_data_q, out_data_d;
  logic                  out_free;
  logic                  in_acc;
  logic                  last;
  logic [CntW-1:0]       idx_inc;
  logic signed [33:0]    dxy, sum;
  logic signed [31:0]    sum_sat;
  logic signed [33:0]    z_rnd, w_rnd;
  logic signed [18:0]    z_sh, w_sh;
  logic signed [15:0]    z_q15, w_q15;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign idx_inc     = idx_q + CntW'(1);
  assign last        = (idx_inc == steps_q);

  assign c_last = (iter_q == IterW'(CORDIC_ITERS - 1));
  assign xs     = cx_q >>> iter_q;
  assign ys     = cy_q >>> iter_q;
  assign c_atan = 34'(ucr_atan(5'(iter_q)));
  assign cos_v  = flip_q ? -cx_q : cx_q;
  assign sin_v  = flip_q ? -cy_q : cy_q;

  assign c_flip  = c_ang[31] ^ c_ang[30];
  assign c_ang_f = c_flip ? {~c_ang[31], c_ang[30:0]} : c_ang;

  assign mul_d = 65'(mul_a) * 65'(mul_b);

  assign dxy = 34'(mul_q >>> 30);
  always_comb begin
    if (state_q == S_MUL_Y) begin
      sum = 34'(acc_x_q) + dxy;
    end else begin
      sum = 34'(acc_y_q) + dxy;
    end
    if (sum > 34'sd2147483647) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum < -34'sd2147483648) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  assign z_rnd = 34'(sin_v) + 34'sd16384;
  assign w_rnd = 34'(cos_v) + 34'sd16384;
  assign z_sh  = 19'(z_rnd >>> 15);
  assign w_sh  = 19'(w_rnd >>> 15);
  always_comb begin
    if (z_sh > 19'sd32767) begin
      z_q15 = 16'sh7FFF;
    end else if (z_sh < -19'sd32768) begin
      z_q15 = 16'sh8000;
    end else begin
      z_q15 = z_sh[15:0];
    end
    if (w_sh > 19'sd32767) begin
      w_q15 = 16'sh7FFF;
    end else if (w_sh < -19'sd32768) begin
      w_q15 = 16'sh8000;
    end else begin
      w_q15 = w_sh[15:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    steps_d      = steps_q;
    idx_d        = idx_q;
    step_delta_d = step_delta_q;
    turn_delta_d = turn_delta_q;
    heading_d    = heading_q;
    acc_x_d      = acc_x_q;
    acc_y_d      = acc_y_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    mul_a        = 33'(step_delta_q);
    mul_b        = cos_v[31:0];
    c_start      = 1'b0;
    c_ang        = {heading_q[30:0], 1'b0};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = in_data_i;
          if (step_count_q > StepCountW'(MAX_STEPS)) begin
            steps_d = CntW'(MAX_STEPS);
          end else begin
            steps_d = CntW'(step_count_q);
          end
          state_d = S_MUL_V;
        end
      end
      S_MUL_V: begin
        mul_a   = 33'(cmd_q.linear_velocity);
        mul_b   = 32'(time_step_q);
        state_d = S_MUL_W;
      end
      S_MUL_W: begin
        mul_a        = 33'(cmd_q.angular_velocity);
        mul_b        = 32'(time_step_q);
        step_delta_d = 25'(mul_q >>> 8);
        state_d      = S_MUL_T;
      end
      S_MUL_T: begin
        mul_a   = mul_q[32:0];
        mul_b   = RAD_TO_HALF;
        state_d = S_CAP_T;
      end
      S_CAP_T: begin
        turn_delta_d = mul_q[47:16];
        heading_d    = '0;
        acc_x_d      = '0;
        acc_y_d      = '0;
        idx_d        = '0;
        c_ang        = '0;
        if (steps_q == '0) begin
          state_d = S_IDLE;
        end else begin
          c_start = 1'b1;
          state_d = S_CMOVE;
        end
      end
      S_CMOVE: begin
        if (c_last) begin
          state_d = S_MUL_X;
        end
      end
      S_MUL_X: begin
        state_d = S_MUL_Y;
      end
      S_MUL_Y: begin
        mul_b   = sin_v[31:0];
        acc_x_d = sum_sat;
        state_d = S_ADD_Y;
      end
      S_ADD_Y: begin
        acc_y_d   = sum_sat;
        heading_d = heading_q + turn_delta_q;
        c_ang     = heading_q + turn_delta_q;
        c_start   = 1'b1;
        state_d   = S_CQUAT;
      end
      S_CQUAT: begin
        if (c_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_data_d.pos_x     = acc_x_q;
          out_data_d.pos_y     = acc_y_q;
          out_data_d.orient_z  = z_q15;
          out_data_d.orient_w  = w_q15;
          out_data_d.last_pose = last;
          if (last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            c_start = 1'b1;
            state_d = S_CMOVE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    cz_d   = cz_q;
    flip_d = flip_q;
    iter_d = iter_q;
    if (c_start) begin
      cx_d   = CORDIC_GAIN;
      cy_d   = '0;
      cz_d   = 34'(signed'(c_ang_f));
      flip_d = c_flip;
      iter_d = '0;
    end else if ((state_q == S_CMOVE) || (state_q == S_CQUAT)) begin
      if (!cz_q[33]) begin
        cx_d = cx_q - ys;
        cy_d = cy_q + xs;
        cz_d = cz_q - c_atan;
      end else begin
        cx_d = cx_q + ys;
        cy_d = cy_q - xs;
        cz_d = cz_q + c_atan;
      end
      if (!c_last) begin
        iter_d = iter_q + IterW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      step_count_q <= STEP_COUNT_RST;
      time_step_q  <= TIME_STEP_RST;
      iter_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_COUNT: step_count_q <= cfg_data_i[StepCountW-1:0];
          CFG_TIME_STEP:  time_step_q  <= cfg_data_i[TimeStepW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    steps_q      <= steps_d;
    idx_q        <= idx_d;
    step_delta_q <= step_delta_d;
    turn_delta_q <= turn_delta_d;
    heading_q    <= heading_d;
    acc_x_q      <= acc_x_d;
    acc_y_q      <= acc_y_d;
    mul_q        <= mul_d;
    cx_q         <= cx_d;
    cy_q         <= cy_d;
    cz_q         <= cz_d;
    flip_q       <= flip_d;
    out_data_q   <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block took a command but did not go busy");

  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (idx_q < steps_q))
    else $error("pose index ran past the step count");

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CMOVE) || (state_q == S_CQUAT)) |->
      ({1'b0, iter_q} < (IterW + 1)'(CORDIC_ITERS)))
    else $error("CORDIC iteration counter out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && out_free && last) |=> (state_q == S_IDLE))
    else $error("sequencer did not finish after the last pose");
`endif

endmodule
